>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 10;
  localparam int OFF_W     = 22;
  localparam int BB_W      = 13;
  localparam int INIT_W    = 11;
  localparam int FREE_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(OFF_W);

  localparam int DEF_MAX_BLOCKS       = 1024;
  localparam int DEF_BLOCKS_PER_CHUNK = 64;

  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OWNS     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BLOCKS = 2'd1;

  localparam logic [BB_W-1:0]   BB_RESET   = 13'd64;
  localparam logic [INIT_W-1:0] INIT_RESET = 11'd256;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] block_index;
    logic [OFF_W-1:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [IDX_W-1:0]  granted_index;
    logic [OFF_W-1:0]  granted_offset;
    logic              owned;
    logic [FREE_W-1:0] free_blocks;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

endpackage

`default_nettype wire

>>> design/fixed_block_pool_allocator.sv
`default_nettype none
`include "assert_macros.svh"

// Fixed-size block pool allocator.
// Request channel: req is taken at a rising edge with start high and busy low.
// Commands: allocate, free, ownership query, shutdown.
// Result channel: rsp is valid for the single cycle in which done is high; the
// receiver must take it then, there is no back-pressure.
// Sequence: allocate, free and shutdown pass the execute state; done is registered
// as the block returns to idle, and a new request can be taken while done is high. The
// free list links sit in a one-read-port memory read at acceptance.
// An ownership query with a nonzero block size runs a bit-serial remainder unit,
// one offset bit per cycle, in the divide state after the execute state; done is
// registered at the last bit, and no new request is taken before that.
// Configuration: cfg_index/cfg_data, written at cfg_valid && cfg_ready; ready
// is high while idle. block_bytes acts at once, initial_blocks at shutdown only;
// reset uses the default of 256, not a written value.
// Reset: registers return to block_bytes 64, initial_blocks 256, empty free
// list, no blocks handed out. The link memory is not cleared.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS       = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int BLOCKS_PER_CHUNK = fbpa_pkg::DEF_BLOCKS_PER_CHUNK
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  fbpa_pkg::req_t                   req,
  output logic                             done,
  output fbpa_pkg::rsp_t                   rsp,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [fbpa_pkg::BB_W-1:0]        cfg_data
);
  import fbpa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = (CW > BB_W) ? CW : BB_W;
  localparam int EW = CW + BB_W;
  localparam int OW = (EW > OFF_W) ? EW : OFF_W;
  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(OFF_W - 1);

  state_t state, state_next;

  logic [BB_W-1:0]   block_bytes;
  logic [INIT_W-1:0] initial_blocks;
  logic [IDX_W-1:0]  stack_head, stack_head_next;
  logic              stack_empty, stack_empty_next;
  logic [CW-1:0]     fresh_next, fresh_next_next;
  logic [CW-1:0]     provisioned_limit, provisioned_limit_next;
  logic [CW-1:0]     free_total, free_total_next;

  logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]  link_rd;
  req_t              req_q;

  logic [BB_W-1:0]      rem, rem_step;
  logic [BB_W:0]        rem_sh;
  logic [OFF_W-1:0]     div_sh;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [EW-1:0]        span_end, span_prod;

  logic accept, exec_fin, div_load, div_fin, query_div, mem_we;
  logic [CW-1:0] start_blocks, rst_blocks;
  rsp_t rsp_exec, rsp_div;

  function automatic logic [CW-1:0] clamp_blocks(input logic [INIT_W-1:0] n);
    logic [XW-1:0] nw;
    nw = XW'(n);
    if (nw == '0) begin
      clamp_blocks = CW'(1);
    end else if (nw > XW'(MAX_BLOCKS)) begin
      clamp_blocks = CW'(MAX_BLOCKS);
    end else begin
      clamp_blocks = CW'(nw);
    end
  endfunction

  assign start_blocks = clamp_blocks(initial_blocks);
  assign rst_blocks   = clamp_blocks(INIT_RESET);
  assign query_div    = (req_q.cmd == CMD_OWNS) && (block_bytes != '0);
  assign cfg_ready    = !busy;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = query_div ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_cnt == CNT_LAST) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy     = (state != ST_IDLE);
    accept   = start && (state == ST_IDLE);
    exec_fin = 1'b0;
    div_load = 1'b0;
    div_fin  = 1'b0;
    case (state)
      ST_EXEC: begin
        div_load = query_div;
        exec_fin = !query_div;
      end
      ST_DIV: begin
        div_fin = (div_cnt == CNT_LAST);
      end
      default: ;
    endcase
  end

  // pool state update and result of a one-step request
  always_comb begin
    logic [XW-1:0]    room, grow;
    logic [CW-1:0]    depth, free_dec;
    logic [IDX_W-1:0] gidx;
    logic             ok;
    logic [IDX_W+BB_W-1:0] gprod;

    stack_head_next        = stack_head;
    stack_empty_next       = stack_empty;
    fresh_next_next        = fresh_next;
    provisioned_limit_next = provisioned_limit;
    free_total_next        = free_total;
    mem_we                 = 1'b0;
    room                   = XW'(MAX_BLOCKS) - XW'(provisioned_limit);
    grow                   = (XW'(BLOCKS_PER_CHUNK) > room) ? room : XW'(BLOCKS_PER_CHUNK);
    free_dec               = free_total - CW'(1);
    depth                  = free_dec - (provisioned_limit - fresh_next);
    gidx                   = '0;
    ok                     = 1'b1;

    if (state == ST_EXEC) begin
      case (req_q.cmd)
        CMD_ALLOC: begin
          if (!stack_empty) begin
            gidx             = stack_head;
            stack_head_next  = link_rd;
            free_total_next  = free_dec;
            stack_empty_next = (depth == '0);
          end else if (fresh_next >= provisioned_limit &&
                       provisioned_limit >= CW'(MAX_BLOCKS)) begin
            ok = 1'b0;
          end else begin
            // grow by one chunk, or by the room left below MAX_BLOCKS, when the provisioned range is used up
            if (fresh_next >= provisioned_limit) begin
              provisioned_limit_next = provisioned_limit + CW'(grow);
              free_total_next        = free_total + CW'(grow) - CW'(1);
            end else begin
              free_total_next        = free_dec;
            end
            gidx            = IDX_W'(fresh_next);
            fresh_next_next = fresh_next + CW'(1);
          end
        end
        CMD_FREE: begin
          if (free_total < CW'(MAX_BLOCKS) &&
              XW'(req_q.block_index) < XW'(MAX_BLOCKS)) begin
            mem_we           = 1'b1;
            stack_head_next  = req_q.block_index;
            stack_empty_next = 1'b0;
            free_total_next  = free_total + CW'(1);
          end
        end
        CMD_SHUTDOWN: begin
          stack_head_next        = '0;
          stack_empty_next       = 1'b1;
          fresh_next_next        = '0;
          provisioned_limit_next = start_blocks;
          free_total_next        = start_blocks;
        end
        default: ;
      endcase
    end

    gprod                   = gidx * block_bytes;
    rsp_exec.status         = !ok;
    rsp_exec.granted_index  = gidx;
    rsp_exec.granted_offset = OFF_W'(gprod);
    rsp_exec.owned          = 1'b0;
    rsp_exec.free_blocks    = FREE_W'(free_total_next);
  end

  assign span_prod = provisioned_limit * block_bytes;

  // one remainder bit per cycle
  assign rem_sh   = {rem, div_sh[OFF_W-1]};
  assign rem_step = (rem_sh >= {1'b0, block_bytes}) ?
                    BB_W'(rem_sh - {1'b0, block_bytes}) : BB_W'(rem_sh);

  always_comb begin
    rsp_div.status         = 1'b0;
    rsp_div.granted_index  = '0;
    rsp_div.granted_offset = '0;
    rsp_div.owned          = (OW'(req_q.byte_offset) < OW'(span_end)) && (rem_step == '0);
    rsp_div.free_blocks    = FREE_W'(free_total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      done              <= 1'b0;
      block_bytes       <= BB_RESET;
      initial_blocks    <= INIT_RESET;
      stack_head        <= '0;
      stack_empty       <= 1'b1;
      fresh_next        <= '0;
      provisioned_limit <= rst_blocks;
      free_total        <= rst_blocks;
    end else begin
      state             <= state_next;
      done              <= exec_fin || div_fin;
      stack_head        <= stack_head_next;
      stack_empty       <= stack_empty_next;
      fresh_next        <= fresh_next_next;
      provisioned_limit <= provisioned_limit_next;
      free_total        <= free_total_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_BYTES:    block_bytes    <= cfg_data;
          CFG_INITIAL_BLOCKS: initial_blocks <= cfg_data[INIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    // fetch the link under the head while the request is taken
    if (accept) begin
      req_q   <= req;
      link_rd <= link_mem[IW'(stack_head)];
    end
    if (mem_we) begin
      link_mem[IW'(req_q.block_index)] <= stack_empty ? '0 : stack_head;
    end
    if (div_load) begin
      rem      <= '0;
      div_sh   <= req_q.byte_offset;
      div_cnt  <= '0;
      span_end <= span_prod;
    end else if (state == ST_DIV) begin
      rem     <= rem_step;
      div_sh  <= {div_sh[OFF_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (exec_fin) begin
      rsp <= rsp_exec;
    end else if (div_fin) begin
      rsp <= rsp_div;
    end
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted request left block idle")
  `ASSERT_IMPLY(a_done_after_work, clk, rst, done, $past(busy), "result without work")
  `ASSERT_IMPLY(a_fresh_bound, clk, rst, 1'b1, fresh_next <= provisioned_limit, "fresh beyond limit")
  `ASSERT_IMPLY(a_limit_bound, clk, rst, 1'b1, provisioned_limit <= CW'(MAX_BLOCKS), "limit too big")

endmodule

`default_nettype wire
